// File: hdl/mhp_pkg.sv
// Package for the message header parser: phase codes, status codes, shared types.
// No dependencies.
`default_nettype none
package mhp_pkg;
	localparam logic [7:0] VERSION_MASK = 8'hF0;

	localparam logic [3:0] PH_FLAGS    = 4'd0;
	localparam logic [3:0] PH_SESSION  = 4'd1;
	localparam logic [3:0] PH_SECURITY = 4'd2;
	localparam logic [3:0] PH_COUNTER  = 4'd3;
	localparam logic [3:0] PH_SOURCE   = 4'd4;
	localparam logic [3:0] PH_DNODE    = 4'd5;
	localparam logic [3:0] PH_GROUP    = 4'd6;
	localparam logic [3:0] PH_EXTLEN   = 4'd7;
	localparam logic [3:0] PH_SKIP     = 4'd8;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_VERSION   = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_RESERVED  = 3'd3;
	localparam logic [2:0] ST_BOTH_DEST = 3'd4;
	localparam logic [2:0] ST_GROUP     = 3'd5;
	localparam logic [2:0] ST_EXT_LONG  = 3'd6;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [16:0] header_length;
		logic [7:0]  message_flags;
		logic [15:0] session_id;
		logic [7:0]  security_flags;
		logic [31:0] message_counter;
		logic [63:0] src_node_id;
		logic [63:0] destination_node_id;
		logic [15:0] destination_group_id;
	} result_t;
endpackage
`default_nettype wire

// File: hdl/mhp_front.sv
// Front: accepts byte requests into a short queue toward the parser.
// Depends on mhp_pkg.
`default_nettype none
module mhp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mhp_pkg::byte_req_t in_req,
	output logic                    q_valid,
	input  wire logic               q_take,
	output mhp_pkg::byte_req_t      q_req
);
	mhp_pkg::byte_req_t mem_q [mhp_pkg::QDEPTH];
	logic [mhp_pkg::QAW-1:0] wr_q, rd_q;
	logic [mhp_pkg::QAW:0]   cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (mhp_pkg::QAW+1)'(mhp_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_take;
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (mhp_pkg::QAW+1)'(push) - (mhp_pkg::QAW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (mhp_pkg::QAW+1)'(mhp_pkg::QDEPTH))
		else $error("queue count overflow");
	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");
`endif
endmodule
`default_nettype wire

// File: hdl/mhp_back.sv
// Back: field parser state machine with a registered result stage.
// Depends on mhp_pkg.
`default_nettype none
module mhp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [3:0]         expected_version,
	input  wire logic               q_valid,
	output logic                    q_take,
	input  wire mhp_pkg::byte_req_t q_req,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output mhp_pkg::result_t        res
);
	logic [3:0]  phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [16:0] cons_q, cons_d;
	logic [7:0]  flags_q, flags_d, sec_q, sec_d;
	logic [15:0] sess_q, sess_d, grp_q, grp_d, skip_q, skip_d;
	logic [31:0] cnt_q, cnt_d;
	logic [63:0] src_q, src_d, dn_q, dn_d;
	logic        given_q, given_d;
	logic        emit;
	logic [2:0]  st;
	logic [3:0]  idx_n;
	logic [5:0]  sh;
	logic [7:0]  b;
	logic        last;
	mhp_pkg::result_t r_d;

	// room in the result register if empty or being taken this cycle
	assign q_take = !res_valid || !res_stall;
	assign b    = q_req.data_byte;
	assign last = q_req.last_byte;
	assign idx_n = idx_q + 4'd1;
	assign sh = {idx_q[2:0], 3'b000};

	always_comb begin
		logic [1:0] stype, dsiz;
		logic route, tail;
		phase_d = phase_q; idx_d = idx_q; cons_d = cons_q;
		flags_d = flags_q; sec_d = sec_q; sess_d = sess_q; grp_d = grp_q;
		skip_d = skip_q; cnt_d = cnt_q; src_d = src_q; dn_d = dn_q;
		given_d = given_q;
		emit = 1'b0; st = mhp_pkg::ST_OK;
		route = 1'b0; tail = 1'b0;
		stype = sec_q[1:0]; dsiz = flags_q[1:0];
		if (given_q || phase_q > mhp_pkg::PH_SKIP) begin
			emit = 1'b0;
		end else begin
			emit = 1'b1;
			st = mhp_pkg::ST_OK;
			cons_d = cons_q + 17'd1;
			case (phase_q)
				mhp_pkg::PH_FLAGS: begin
					flags_d = b;
					if (((b & mhp_pkg::VERSION_MASK) >> 4) != {4'd0, expected_version})
						st = mhp_pkg::ST_VERSION;
					else begin
						phase_d = mhp_pkg::PH_SESSION; emit = 1'b0;
					end
				end
				mhp_pkg::PH_SESSION: begin
					sess_d = sess_q | (16'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd2) begin
						idx_d = '0; phase_d = mhp_pkg::PH_SECURITY;
					end else idx_d = idx_n;
				end
				mhp_pkg::PH_SECURITY: begin
					sec_d = b; phase_d = mhp_pkg::PH_COUNTER; emit = 1'b0;
				end
				mhp_pkg::PH_COUNTER: begin
					cnt_d = cnt_q | (32'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd4) begin
						idx_d = '0;
						if (flags_q[2]) phase_d = mhp_pkg::PH_SOURCE;
						else route = 1'b1;
					end else idx_d = idx_n;
				end
				mhp_pkg::PH_SOURCE: begin
					src_d = src_q | (64'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd8) begin
						idx_d = '0; route = 1'b1;
					end else idx_d = idx_n;
				end
				mhp_pkg::PH_DNODE: begin
					dn_d = dn_q | (64'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd8) begin
						idx_d = '0; tail = 1'b1;
					end else idx_d = idx_n;
				end
				mhp_pkg::PH_GROUP: begin
					grp_d = grp_q | (16'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd2) begin
						idx_d = '0; tail = 1'b1;
					end else idx_d = idx_n;
				end
				mhp_pkg::PH_EXTLEN: begin
					skip_d = skip_q | (16'(b) << sh);
					emit = 1'b0;
					if (idx_n >= 4'd2) begin
						idx_d = '0;
						if (skip_d == '0) emit = 1'b1;
						else phase_d = mhp_pkg::PH_SKIP;
					end else idx_d = idx_n;
				end
				default: begin
					if (skip_q != '0) skip_d = skip_q - 16'd1;
					emit = (skip_d == '0);
				end
			endcase
			if (route) begin
				if (stype >= 2'd2) begin
					emit = 1'b1; st = mhp_pkg::ST_RESERVED;
				end else if (dsiz == 2'd3) begin
					emit = 1'b1; st = mhp_pkg::ST_BOTH_DEST;
				end else if (dsiz == 2'd1) phase_d = mhp_pkg::PH_DNODE;
				else if (dsiz == 2'd2) begin
					if (stype != 2'd1) begin
						emit = 1'b1; st = mhp_pkg::ST_GROUP;
					end else phase_d = mhp_pkg::PH_GROUP;
				end else tail = 1'b1;
			end
			if (tail) begin
				if (sec_q[5]) phase_d = mhp_pkg::PH_EXTLEN;
				else begin
					emit = 1'b1; st = mhp_pkg::ST_OK;
				end
			end
			if (!emit && last) begin
				emit = 1'b1;
				st = (phase_d == mhp_pkg::PH_SKIP) ? mhp_pkg::ST_EXT_LONG
					: mhp_pkg::ST_TRUNC;
			end
			if (emit && !last) given_d = 1'b1;
		end
		r_d = '0;
		r_d.status = st;
		if (st == mhp_pkg::ST_OK) begin
			r_d.header_length        = cons_d;
			r_d.message_flags        = flags_d;
			r_d.session_id           = sess_d;
			r_d.security_flags       = sec_d;
			r_d.message_counter      = cnt_d;
			r_d.src_node_id          = src_d;
			r_d.destination_node_id  = dn_d;
			r_d.destination_group_id = grp_d;
		end
		if (last) begin
			phase_d = mhp_pkg::PH_FLAGS; idx_d = '0; cons_d = '0;
			flags_d = '0; sec_d = '0; sess_d = '0; grp_d = '0; skip_d = '0;
			cnt_d = '0; src_d = '0; dn_d = '0; given_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mhp_pkg::PH_FLAGS; idx_q <= '0; cons_q <= '0;
			flags_q <= '0; sec_q <= '0; sess_q <= '0; grp_q <= '0; skip_q <= '0;
			cnt_q <= '0; src_q <= '0; dn_q <= '0; given_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (q_valid && q_take) begin
				phase_q <= phase_d; idx_q <= idx_d; cons_q <= cons_d;
				flags_q <= flags_d; sec_q <= sec_d; sess_q <= sess_d; grp_q <= grp_d;
				skip_q <= skip_d; cnt_q <= cnt_d; src_q <= src_d; dn_q <= dn_d;
				given_q <= given_d;
			end
			if (q_take) res_valid <= q_valid && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && q_valid && emit) res <= r_d;
	end

`ifndef SYNTHESIS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid && $stable(res))
		else $error("stalled result changed");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != mhp_pkg::ST_OK) |-> res.header_length == '0)
		else $error("failed result carries length");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < 4'd8)
		else $error("byte index out of range");
`endif
endmodule
`default_nettype wire

// File: hdl/message_header_parser_top.sv
// Top level of the message header parser: request queue plus field parser.
// The byte that completes or fails the header passes through the queue and then the result
// register before out_valid rises; bytes still queued ahead of it behind an output stall hold it back.
// Throughput: one byte per cycle while out_stall does not hold the result register.
// The 2-entry queue and result register decouple input and output stalls.
// Reset (arst_n low, asynchronous): queue empty, parser at message flags, version 0.
`default_nettype none
module message_header_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [16:0]      header_length,
	output logic [7:0]       message_flags,
	output logic [15:0]      session_id,
	output logic [7:0]       security_flags,
	output logic [31:0]      message_counter,
	output logic [63:0]      src_node_id,
	output logic [63:0]      destination_node_id,
	output logic [15:0]      destination_group_id
);
	logic [3:0] version_q;
	mhp_pkg::byte_req_t in_req, q_req;
	mhp_pkg::result_t   res;
	logic q_valid, q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) version_q <= '0;
		else if (cfg_we) version_q <= cfg_wdata;
	end

	assign in_req.data_byte = data_byte;
	assign in_req.last_byte = last_byte;

	mhp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
	);

	mhp_back u_back (
		.clk(clk), .arst_n(arst_n), .expected_version(version_q),
		.q_valid(q_valid), .q_take(q_take), .q_req(q_req),
		.res_valid(out_valid), .res_stall(out_stall), .res(res)
	);

	assign status               = res.status;
	assign header_length        = res.header_length;
	assign message_flags        = res.message_flags;
	assign session_id           = res.session_id;
	assign security_flags       = res.security_flags;
	assign message_counter      = res.message_counter;
	assign src_node_id          = res.src_node_id;
	assign destination_node_id  = res.destination_node_id;
	assign destination_group_id = res.destination_group_id;
endmodule
`default_nettype wire

// File: tb/tb_message_header_parser_top.sv
// Testbench for message_header_parser_top: random and directed byte streams checked
// against a cycle-free header parse predictor. Depends on hdl/mhp_pkg.sv and the top.
`timescale 1ns / 1ps
module tb_message_header_parser_top;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       pause_drain;
	} req_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [16:0] header_length;
	logic [7:0]  message_flags;
	logic [15:0] session_id;
	logic [7:0]  security_flags;
	logic [31:0] message_counter;
	logic [63:0] src_node_id;
	logic [63:0] destination_node_id;
	logic [15:0] destination_group_id;
	mhp_pkg::result_t got;

	message_header_parser_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .header_length(header_length),
		.message_flags(message_flags), .session_id(session_id),
		.security_flags(security_flags), .message_counter(message_counter),
		.src_node_id(src_node_id), .destination_node_id(destination_node_id),
		.destination_group_id(destination_group_id)
	);

	assign got = {status, header_length, message_flags, session_id, security_flags,
		message_counter, src_node_id, destination_node_id, destination_group_id};

	req_t             pending_bytes[$];
	mhp_pkg::result_t expected_headers[$];
	int      errors = 0;
	bit      hold_long = 0;

	// predictor state
	logic [3:0]  p_version;
	logic [3:0]  p_phase;
	logic [3:0]  p_idx;
	logic [16:0] p_count;
	logic [7:0]  p_flags;
	logic [7:0]  p_sec;
	logic [15:0] p_session;
	logic [31:0] p_counter;
	logic [63:0] p_source;
	logic [63:0] p_dnode;
	logic [15:0] p_group;
	logic [15:0] p_skip;
	bit          p_done;

	function automatic void clear_header();
		p_phase = mhp_pkg::PH_FLAGS; p_idx = 0; p_count = 0; p_flags = 0; p_sec = 0;
		p_session = 0; p_counter = 0; p_source = 0; p_dnode = 0; p_group = 0;
		p_skip = 0; p_done = 0;
	endfunction

	// accumulate byte into little endian field; returns 1 when n bytes are in
	function automatic bit take(inout logic [63:0] acc, input logic [7:0] b, input int n);
		acc = acc | (64'(b) << (8 * p_idx[2:0]));
		p_idx = p_idx + 1;
		if (p_idx >= n) begin
			p_idx = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic int route_after_dest();
		if (p_sec[5]) begin
			p_phase = mhp_pkg::PH_EXTLEN;
			return -1;
		end
		return mhp_pkg::ST_OK;
	endfunction

	function automatic int route_dest();
		if (p_sec[1:0] >= 2) return mhp_pkg::ST_RESERVED;
		if (p_flags[1:0] == 3) return mhp_pkg::ST_BOTH_DEST;
		if (p_flags[1:0] == 1) begin
			p_phase = mhp_pkg::PH_DNODE;
			return -1;
		end
		if (p_flags[1:0] == 2) begin
			if (p_sec[1:0] != 1) return mhp_pkg::ST_GROUP;
			p_phase = mhp_pkg::PH_GROUP;
			return -1;
		end
		return route_after_dest();
	endfunction

	task automatic predict_header(input logic [7:0] b, input logic last);
		int st;
		logic [63:0] acc;
		mhp_pkg::result_t r;
		st = -1;
		if (p_done || p_phase > mhp_pkg::PH_SKIP) begin
			if (last) clear_header();
			return;
		end
		p_count = p_count + 1;
		case (p_phase)
			mhp_pkg::PH_FLAGS: begin
				p_flags = b;
				if (((b & mhp_pkg::VERSION_MASK) >> 4) != p_version) st = mhp_pkg::ST_VERSION;
				else p_phase = mhp_pkg::PH_SESSION;
			end
			mhp_pkg::PH_SESSION: begin
				acc = 64'(p_session);
				if (take(acc, b, 2)) p_phase = mhp_pkg::PH_SECURITY;
				p_session = acc[15:0];
			end
			mhp_pkg::PH_SECURITY: begin
				p_sec = b;
				p_phase = mhp_pkg::PH_COUNTER;
			end
			mhp_pkg::PH_COUNTER: begin
				acc = 64'(p_counter);
				if (take(acc, b, 4)) begin
					p_counter = acc[31:0];
					if (p_flags[2]) p_phase = mhp_pkg::PH_SOURCE;
					else st = route_dest();
				end
				p_counter = acc[31:0];
			end
			mhp_pkg::PH_SOURCE: begin
				acc = p_source;
				if (take(acc, b, 8)) begin
					p_source = acc;
					st = route_dest();
				end
				p_source = acc;
			end
			mhp_pkg::PH_DNODE: begin
				acc = p_dnode;
				if (take(acc, b, 8)) begin
					p_dnode = acc;
					st = route_after_dest();
				end
				p_dnode = acc;
			end
			mhp_pkg::PH_GROUP: begin
				acc = 64'(p_group);
				if (take(acc, b, 2)) begin
					p_group = acc[15:0];
					st = route_after_dest();
				end
				p_group = acc[15:0];
			end
			mhp_pkg::PH_EXTLEN: begin
				acc = 64'(p_skip);
				if (take(acc, b, 2)) begin
					p_skip = acc[15:0];
					if (p_skip == 0) st = mhp_pkg::ST_OK;
					else p_phase = mhp_pkg::PH_SKIP;
				end else begin
					p_skip = acc[15:0];
				end
			end
			default: begin
				if (p_skip > 0) p_skip = p_skip - 1;
				if (p_skip == 0) st = mhp_pkg::ST_OK;
			end
		endcase
		if (st < 0) begin
			if (!last) return;
			st = (p_phase == mhp_pkg::PH_SKIP) ? mhp_pkg::ST_EXT_LONG : mhp_pkg::ST_TRUNC;
		end
		r = '0;
		r.status = st[2:0];
		if (st == mhp_pkg::ST_OK) begin
			r.header_length = p_count; r.message_flags = p_flags; r.session_id = p_session;
			r.security_flags = p_sec; r.message_counter = p_counter;
			r.src_node_id = p_source; r.destination_node_id = p_dnode;
			r.destination_group_id = p_group;
		end
		expected_headers.push_back(r);
		if (last) clear_header();
		else p_done = 1;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last, input bit drain = 0);
		req_t q;
		q.data_byte = b; q.last_byte = last; q.pause_drain = drain;
		pending_bytes.push_back(q);
	endtask

	// well formed header with random content; corrupt > 0 breaks it somehow
	task automatic push_header(input logic [3:0] ver, input int corrupt);
		logic [7:0] fl, sc;
		int n, ext, total, cut;
		logic [7:0] hb[$];
		fl = {ver, 1'b0, 1'($urandom), 2'($urandom_range(0, 2))};
		sc = {3'($urandom), 3'($urandom), 2'd1};
		if (fl[1:0] == 0 && $urandom_range(0, 1)) sc[1:0] = 0;
		if (corrupt == 1) fl[7:4] = ~ver;
		if (corrupt == 2) sc[1:0] = 2'($urandom_range(2, 3));
		if (corrupt == 3) fl[1:0] = 3;
		if (corrupt == 4) begin
			fl[1:0] = 2; sc[1:0] = 0;
		end
		ext = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
		hb.push_back(fl);
		repeat (3) hb.push_back(8'($urandom));
		hb[3] = sc;
		repeat (4) hb.push_back(8'($urandom));
		if (fl[2]) repeat (8) hb.push_back(8'($urandom));
		if (fl[1:0] == 1) repeat (8) hb.push_back(8'($urandom));
		if (fl[1:0] == 2) repeat (2) hb.push_back(8'($urandom));
		if (sc[5]) begin
			hb.push_back(8'(ext)); hb.push_back(8'(ext >> 8));
			repeat (ext) hb.push_back(8'($urandom));
		end
		total = hb.size();
		cut = total;
		if (corrupt == 5) cut = $urandom_range(1, total - 1 > 0 ? total - 1 : 1);
		n = $urandom_range(0, 3);
		for (int i = 0; i < cut; i++)
			push_byte(hb[i], (i == cut - 1) && (n == 0 || cut < total));
		if (cut == total && n > 0)
			for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// driver
	int in_wait = 0;
	bit waiting_drain = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0; data_byte <= 0; last_byte <= 0;
			in_wait = $urandom_range(0, 4);
		end else begin
			if (in_valid && !in_stall) begin
				predict_header(data_byte, last_byte);
				in_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end
			if (!(in_valid && in_stall)) begin
				if (pending_bytes.size() > 0 && pending_bytes[0].pause_drain)
					waiting_drain = 1;
				if (waiting_drain && expected_headers.size() == 0 && !out_valid) begin
					waiting_drain = 0;
					pending_bytes[0].pause_drain = 0;
				end
				if (pending_bytes.size() > 0 && !waiting_drain && in_wait == 0) begin
					in_valid <= 1;
					data_byte <= pending_bytes[0].data_byte;
					last_byte <= pending_bytes[0].last_byte;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 0;
					if (in_wait > 0) in_wait--;
				end
			end
		end
	end

	// monitor and output stall
	int out_wait = 0;
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_headers.size() == 0) begin
					$error("result with nothing expected, status %0d", got.status);
					errors++;
				end else begin
					mhp_pkg::result_t e;
					e = expected_headers.pop_front();
					if (got.status != e.status) begin
						$error("status exp %0d got %0d", e.status, got.status); errors++;
					end
					if (got.header_length != e.header_length) begin
						$error("header_length exp %0d got %0d", e.header_length,
							got.header_length); errors++;
					end
					if (got.message_flags != e.message_flags) begin
						$error("message_flags exp %h got %h", e.message_flags,
							got.message_flags); errors++;
					end
					if (got.session_id != e.session_id) begin
						$error("session_id exp %h got %h", e.session_id, got.session_id);
						errors++;
					end
					if (got.security_flags != e.security_flags) begin
						$error("security_flags exp %h got %h", e.security_flags,
							got.security_flags); errors++;
					end
					if (got.message_counter != e.message_counter) begin
						$error("message_counter exp %h got %h", e.message_counter,
							got.message_counter); errors++;
					end
					if (got.src_node_id != e.src_node_id) begin
						$error("src_node_id exp %h got %h", e.src_node_id,
							got.src_node_id); errors++;
					end
					if (got.destination_node_id != e.destination_node_id) begin
						$error("destination_node_id exp %h got %h", e.destination_node_id,
							got.destination_node_id); errors++;
					end
					if (got.destination_group_id != e.destination_group_id) begin
						$error("destination_group_id exp %h got %h",
							e.destination_group_id, got.destination_group_id); errors++;
					end
				end
				out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end
			if (hold_long && hold_cnt == 0) hold_cnt = 300;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0) hold_long = 0;
				out_stall <= 1;
			end else if (out_wait > 0) begin
				out_wait--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || in_valid || expected_headers.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_version(input logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		p_version = v;
	endtask

	initial begin
		logic [3:0] vers[4];
		vers = '{4'd0, 4'd15, 4'd5, 4'd10};
		arst_n = 0; cfg_we = 0; cfg_wdata = 0;
		p_version = 0;
		clear_header();
		repeat (3) @(posedge clk);
		arst_n <= 0;
		#1 arst_n = 1;

		// directed: extremes and every status, at reset version 0
		push_byte(8'h00, 1);                       // truncated after flags
		push_byte(8'hF0, 0); push_byte(8'hFF, 1);  // version mismatch, rest ignored
		for (int c = 0; c <= 5; c++) push_header(4'd0, c);
		// max fields: source + node, no extension
		push_byte(8'h05, 0); push_byte(8'hFF, 0); push_byte(8'hFF, 0);
		push_byte(8'h01, 0);
		repeat (18) push_byte(8'hFF, 0);
		push_byte(8'hAA, 0);
		push_byte(8'h55, 1);
		// extension runs past the end
		push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
		push_byte(8'h20, 0);
		repeat (4) push_byte(8'h00, 0);
		push_byte(8'h05, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			write_version(vers[ph]);
			for (int k = 0; k < 27; k++) begin
				if (k == 10 && ph == 1) hold_long = 1;
				if ($urandom_range(0, 9) < 7) push_header(vers[ph], 0);
				else if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 6))
						push_byte(8'($urandom), 1'($urandom_range(0, 1)));
				else push_header(vers[ph], $urandom_range(1, 5));
				if (k == 15) pending_bytes[$].pause_drain = 1;
			end
			wait_idle();
		end
		// largest extension length, cut short by the last byte
		push_byte({vers[3], 4'h0}, 0); repeat (2) push_byte(8'h11, 0);
		push_byte(8'h20, 0); repeat (4) push_byte(8'h22, 0);
		push_byte(8'hFF, 0); push_byte(8'hFF, 0);
		repeat (20) push_byte(8'($urandom), 0);
		push_byte(8'h00, 1);
		wait_idle();

		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: sim.f
hdl/mhp_pkg.sv
hdl/mhp_front.sv
hdl/mhp_back.sv
hdl/message_header_parser_top.sv
tb/tb_message_header_parser_top.sv
